// ===== src/bpc_pkg.sv =====
// shared types and constants for the button press classifier
// no dependencies; imported by every module of the block
package bpc_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int LEVEL_BITS  = 8;
    localparam int TIMER_W     = 16;
    localparam int BTN_W       = 3;
    localparam int SEL_W       = 6;
    localparam int FUNC_W      = 2;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 8;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SCAN     = 2'd0,
        FUNC_RD_LONG  = 2'd1,
        FUNC_RD_SHORT = 2'd2,
        FUNC_RD_PRESS = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_SHORT_MIN  = 2'd0,
        REG_LONG_LIMIT = 2'd1,
        REG_IDLE_RESET = 2'd2
    } reg_idx_t;

    localparam logic [TIMER_W-1:0] SHORT_MIN_RST  = 16'd2;
    localparam logic [TIMER_W-1:0] LONG_LIMIT_RST = 16'd100;
    localparam logic [TIMER_W-1:0] IDLE_RESET_RST = 16'd500;

    typedef struct packed {
        logic [TIMER_W-1:0] short_min;
        logic [TIMER_W-1:0] long_limit;
        logic [TIMER_W-1:0] idle_reset;
    } cfg_t;

    typedef struct packed {
        logic scan;
        logic up;
        logic clr_long;
        logic clr_short;
    } btn_ctl_t;

    typedef struct packed {
        logic pressed;
        logic short_flag;
        logic long_flag;
    } btn_stat_t;

endpackage

// ===== src/bpc_cfg.sv =====
// apb register file holding the three timing thresholds
// depends on bpc_pkg
module bpc_cfg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [bpc_pkg::APB_AW-1:0] paddr,
    input  logic [bpc_pkg::APB_DW-1:0] pwdata,
    output logic [bpc_pkg::APB_DW-1:0] prdata,
    output logic                   pready,
    output bpc_pkg::cfg_t          cfg
);
    import bpc_pkg::*;

    logic [TIMER_W-1:0] short_min_reg,  short_min_next;
    logic [TIMER_W-1:0] long_limit_reg, long_limit_next;
    logic [TIMER_W-1:0] idle_reset_reg, idle_reset_next;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_comb begin
        short_min_next  = short_min_reg;
        long_limit_next = long_limit_reg;
        idle_reset_next = idle_reset_reg;
        if (wr_en) begin
            case (idx)
                REG_SHORT_MIN:  short_min_next  = pwdata[TIMER_W-1:0];
                REG_LONG_LIMIT: long_limit_next = pwdata[TIMER_W-1:0];
                REG_IDLE_RESET: idle_reset_next = pwdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SHORT_MIN:  prdata = APB_DW'(short_min_reg);
            REG_LONG_LIMIT: prdata = APB_DW'(long_limit_reg);
            REG_IDLE_RESET: prdata = APB_DW'(idle_reset_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_min_reg  <= SHORT_MIN_RST;
            long_limit_reg <= LONG_LIMIT_RST;
            idle_reset_reg <= IDLE_RESET_RST;
        end else begin
            short_min_reg  <= short_min_next;
            long_limit_reg <= long_limit_next;
            idle_reset_reg <= idle_reset_next;
        end
    end

    assign cfg.short_min  = short_min_reg;
    assign cfg.long_limit = long_limit_reg;
    assign cfg.idle_reset = idle_reset_reg;

endmodule

// ===== src/bpc_cell.sv =====
// per-button state: press timer, released and blocked marks, press flags
// depends on bpc_pkg
module bpc_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  bpc_pkg::cfg_t      cfg,
    input  bpc_pkg::btn_ctl_t  ctl,
    output bpc_pkg::btn_stat_t stat
);
    import bpc_pkg::*;

    logic [TIMER_W-1:0] cnt_reg,   cnt_next;
    logic               rel_reg,   rel_next;
    logic               blk_reg,   blk_next;
    logic               short_reg, short_next;
    logic               long_reg,  long_next;
    logic [TIMER_W-1:0] cnt_inc;
    logic [TIMER_W-1:0] half_limit;

    // timer saturates at its top value
    assign cnt_inc    = (cnt_reg != '1) ? cnt_reg + 1'b1 : cnt_reg;
    assign half_limit = cfg.long_limit >> 1;

    always_comb begin
        cnt_next   = cnt_reg;
        rel_next   = rel_reg;
        blk_next   = blk_reg;
        short_next = short_reg;
        long_next  = long_reg;
        if (ctl.scan) begin
            if (ctl.up && rel_reg) begin
                // idle: count, then drop unread flags
                if (cnt_reg > cfg.idle_reset) begin
                    short_next = 1'b0;
                    long_next  = 1'b0;
                end else begin
                    cnt_next = cnt_inc;
                end
            end else if (!ctl.up && rel_reg) begin
                // press edge
                rel_next   = 1'b0;
                cnt_next   = '0;
                short_next = 1'b0;
                long_next  = 1'b0;
                blk_next   = 1'b0;
            end else if (!ctl.up) begin
                if (!blk_reg) begin
                    if (cnt_reg > cfg.long_limit) begin
                        long_next = 1'b1;
                        blk_next  = 1'b1;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
            end else begin
                // release edge
                if (cnt_reg > cfg.short_min && cnt_reg < half_limit) begin
                    short_next = 1'b1;
                end
                rel_next = 1'b1;
                cnt_next = '0;
            end
        end else begin
            if (ctl.clr_long) begin
                long_next = 1'b0;
            end
            if (ctl.clr_short) begin
                short_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            rel_reg   <= 1'b1;
            blk_reg   <= 1'b0;
            short_reg <= 1'b0;
            long_reg  <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            rel_reg   <= rel_next;
            blk_reg   <= blk_next;
            short_reg <= short_next;
            long_reg  <= long_next;
        end
    end

    assign stat.pressed    = !rel_reg;
    assign stat.short_flag = short_reg;
    assign stat.long_flag  = long_reg;

endmodule

// ===== src/button_press_classifier_unit.sv =====
// button press classifier: top level with input register, button cells,
// answer mux and result register; depends on bpc_pkg, bpc_cfg, bpc_cell
//
// a query enters the input register; its answer is offered on m_ from the result register
// throughput: one item per cycle; queries stall only while an answer waits
// reset: aresetn synchronous active low; buttons released, timers and flags
// cleared, thresholds back to 2 / 100 / 500
module button_press_classifier_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bpc_pkg::S_DATA_W-1:0] s_tdata,   // levels[7:0], button[10:8]
    input  logic [bpc_pkg::FUNC_W-1:0]   s_tuser,   // func[1:0]
    // result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bpc_pkg::M_DATA_W-1:0] m_tdata,   // answer[0]
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpc_pkg::APB_AW-1:0]   paddr,
    input  logic [bpc_pkg::APB_DW-1:0]   pwdata,
    output logic [bpc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import bpc_pkg::*;

    // input register stage
    logic                  in_vld_reg,    in_vld_next;
    func_t                 in_func_reg;
    logic [LEVEL_BITS-1:0] in_levels_reg;
    logic [BTN_W-1:0]      in_button_reg;

    // result register stage
    logic                  out_vld_reg,   out_vld_next;
    logic                  answer_reg,    answer_next;

    logic                  in_xfer;
    logic                  is_scan;
    logic                  exec_go;
    logic                  exec_query;
    logic                  answer;

    cfg_t                  cfg;
    btn_ctl_t              ctl  [NUM_BUTTONS];
    btn_stat_t             stat [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] sel;

    bpc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // scan ticks never produce a result, so they pass even when the
    // result register is full; a query waits for room
    assign is_scan    = (in_func_reg == FUNC_SCAN);
    assign exec_go    = in_vld_reg && (is_scan || !out_vld_reg || m_tready);
    assign exec_query = exec_go && !is_scan;
    assign s_tready   = !in_vld_reg || exec_go;
    assign in_xfer    = s_tvalid && s_tready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (in_xfer) begin
            in_vld_next = 1'b1;
        end else if (exec_go) begin
            in_vld_next = 1'b0;
        end
    end

    // one cell per button, each with its own level bit and query select
    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
        logic up;
        if (i < LEVEL_BITS) begin : g_lvl
            assign up = in_levels_reg[i];
        end else begin : g_nolvl
            // buttons past the level word always read as released
            assign up = 1'b1;
        end

        assign sel[i] = (SEL_W'(in_button_reg) == SEL_W'(i));

        assign ctl[i].scan      = exec_go && is_scan;
        assign ctl[i].up        = up;
        assign ctl[i].clr_long  = exec_query && sel[i] && (in_func_reg == FUNC_RD_LONG);
        assign ctl[i].clr_short = exec_query && sel[i] && (in_func_reg == FUNC_RD_SHORT);

        bpc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (cfg),
            .ctl     (ctl[i]),
            .stat    (stat[i])
        );
    end

    // answer mux; an out-of-range button selects no cell and reads 0
    always_comb begin
        answer = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            case (in_func_reg)
                FUNC_RD_LONG:  answer = answer | (sel[i] & stat[i].long_flag);
                FUNC_RD_SHORT: answer = answer | (sel[i] & stat[i].short_flag);
                FUNC_RD_PRESS: answer = answer | (sel[i] & stat[i].pressed);
                default:       answer = answer;
            endcase
        end
    end

    // result register: load on a query, drop after the transfer
    always_comb begin
        out_vld_next = out_vld_reg;
        answer_next  = answer_reg;
        if (exec_query) begin
            out_vld_next = 1'b1;
            answer_next  = answer;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_func_reg   <= func_t'(s_tuser);
            in_levels_reg <= s_tdata[LEVEL_BITS-1:0];
            in_button_reg <= s_tdata[LEVEL_BITS+BTN_W-1:LEVEL_BITS];
        end
        answer_reg <= answer_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_DATA_W-1){1'b0}}, answer_reg};

    // a query never overwrites an answer that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_query |-> (!out_vld_reg || m_tready))
        else $error("query executed while result register blocked");

    // every executed query offers an answer in the next cycle
    a_query_result: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_query |=> m_tvalid)
        else $error("query produced no result");

    // a scan tick alone never creates a result
    a_scan_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_go && is_scan && !m_tvalid) |=> !m_tvalid)
        else $error("scan tick produced a result");

    // the input stage drains whenever the downstream side has room
    a_input_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !out_vld_reg) |-> exec_go)
        else $error("input stage stalled with empty result register");

endmodule

// ===== tb/press_tracker_pkg.sv =====
// scoreboard class for the button press classifier testbench: per-button
// timer and flag tracking, queued answers and answer checking; needs bpc_pkg
package press_tracker_pkg;

    import bpc_pkg::*;

    class button_press_tracker;
        logic [TIMER_W-1:0] short_min;
        logic [TIMER_W-1:0] long_limit;
        logic [TIMER_W-1:0] idle_reset;
        logic [TIMER_W-1:0] timer [NUM_BUTTONS];
        bit released [NUM_BUTTONS];
        bit blocked [NUM_BUTTONS];
        bit short_flag [NUM_BUTTONS];
        bit long_flag [NUM_BUTTONS];
        bit answers_due [$];
        int unsigned failures;

        function new();
            short_min  = SHORT_MIN_RST;
            long_limit = LONG_LIMIT_RST;
            idle_reset = IDLE_RESET_RST;
            foreach (timer[i]) begin
                timer[i]      = '0;
                released[i]   = 1'b1;
                blocked[i]    = 1'b0;
                short_flag[i] = 1'b0;
                long_flag[i]  = 1'b0;
            end
            failures = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [TIMER_W-1:0] value);
            case (idx)
                REG_SHORT_MIN:  short_min  = value;
                REG_LONG_LIMIT: long_limit = value;
                REG_IDLE_RESET: idle_reset = value;
                default: ;
            endcase
        endfunction

        function logic [TIMER_W-1:0] read_reg(reg_idx_t idx);
            case (idx)
                REG_SHORT_MIN:  return short_min;
                REG_LONG_LIMIT: return long_limit;
                REG_IDLE_RESET: return idle_reset;
                default:        return '0;
            endcase
        endfunction

        // one accepted input transfer: scan updates every button, queries queue an answer
        function void accept_item(func_t f, logic [LEVEL_BITS-1:0] levels,
                                  logic [BTN_W-1:0] btn);
            bit up;
            bit answer;
            if (f == FUNC_SCAN) begin
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    up = (i < LEVEL_BITS) ? levels[i] : 1'b1;
                    if (up && released[i]) begin
                        // idle count, stale flags dropped past the idle limit
                        if (timer[i] > idle_reset) begin
                            short_flag[i] = 1'b0;
                            long_flag[i]  = 1'b0;
                        end else if (timer[i] != '1) begin
                            timer[i] = timer[i] + 1'b1;
                        end
                    end else if (!up && released[i]) begin
                        released[i]   = 1'b0;
                        timer[i]      = '0;
                        short_flag[i] = 1'b0;
                        long_flag[i]  = 1'b0;
                        blocked[i]    = 1'b0;
                    end else if (!up) begin
                        if (!blocked[i]) begin
                            if (timer[i] > long_limit) begin
                                long_flag[i] = 1'b1;
                                blocked[i]   = 1'b1;
                            end else if (timer[i] != '1) begin
                                timer[i] = timer[i] + 1'b1;
                            end
                        end
                    end else begin
                        if (timer[i] > short_min && timer[i] < (long_limit >> 1))
                            short_flag[i] = 1'b1;
                        released[i] = 1'b1;
                        timer[i]    = '0;
                    end
                end
            end else begin
                answer = 1'b0;
                if (int'(btn) < NUM_BUTTONS) begin
                    case (f)
                        FUNC_RD_LONG: begin
                            answer = long_flag[btn];
                            long_flag[btn] = 1'b0;
                        end
                        FUNC_RD_SHORT: begin
                            answer = short_flag[btn];
                            short_flag[btn] = 1'b0;
                        end
                        default: begin
                            answer = !released[btn];
                        end
                    endcase
                end
                answers_due.push_back(answer);
            end
        endfunction

        function void check_answer(logic actual);
            bit want;
            if (answers_due.size() == 0) begin
                $error("answer: none expected, actual %0b", actual);
                failures++;
            end else begin
                want = answers_due.pop_front();
                if (actual !== want) begin
                    $error("answer mismatch: expected %0b, actual %0b", want, actual);
                    failures++;
                end
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
// top-level testbench for button_press_classifier_unit: drives stream and
// register traffic, checks answers; needs bpc_pkg and press_tracker_pkg
module tb_top;

    import bpc_pkg::*;
    import press_tracker_pkg::*;

    // margin for an answer to pass the input and result registers after its query transfer
    localparam int SETTLE_CYCLES = 4;
    // long receiver hold-off, enough to back the block up into its input
    localparam int HOLD_CYCLES   = 80;
    localparam int PHASE_ITEMS   = 160;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;     // levels[7:0], button[10:8]
    logic [FUNC_W-1:0]     s_tuser;     // func[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;     // answer[0]
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    button_press_tracker tracker = new();

    // sender idling off when calm, receiver idling off when quiet
    bit calm = 1'b0;
    bit quiet = 1'b0;
    // set by the sender, taken by the receiver process
    bit hold_req = 1'b0;
    // button levels as the well-formed scan sequences keep them
    logic [LEVEL_BITS-1:0] levels_now = '1;

    func_t query_kinds [3] = '{FUNC_RD_LONG, FUNC_RD_SHORT, FUNC_RD_PRESS};

    button_press_classifier_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // both channels observed at the clock edge, before any of this edge's updates
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            tracker.accept_item(func_t'(s_tuser), s_tdata[7:0], s_tdata[10:8]);
        if (aresetn && m_tvalid && m_tready)
            tracker.check_answer(m_tdata[0]);
    end

    // one input transfer, with an occasional random gap in front of it
    task automatic issue(input func_t f, input logic [LEVEL_BITS-1:0] lv,
                         input logic [BTN_W-1:0] btn);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= S_DATA_W'({btn, lv});
        do @(posedge aclk); while (!s_tready);
    endtask

    // mostly well-formed scans where buttons hold their level for a while,
    // some noise scans with scrambled levels, and queries at the given share
    task automatic random_item(input int query_pct, input int flip_odds);
        if ($urandom_range(1, 100) <= query_pct) begin
            issue(query_kinds[$urandom_range(0, 2)], LEVEL_BITS'($urandom),
                  BTN_W'($urandom_range(0, NUM_BUTTONS - 1)));
        end else if ($urandom_range(0, 19) == 0) begin
            issue(FUNC_SCAN, LEVEL_BITS'($urandom), BTN_W'($urandom));
        end else begin
            for (int i = 0; i < LEVEL_BITS; i++)
                if ($urandom_range(0, flip_odds) == 0)
                    levels_now[i] = ~levels_now[i];
            issue(FUNC_SCAN, levels_now, BTN_W'($urandom));
        end
    endtask

    // stop offering and wait until every queued answer has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    // setup then access cycle; a read is compared against the tracked register
    task automatic reg_access(input bit wr, input reg_idx_t idx,
                              input logic [TIMER_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (wr) begin
            tracker.write_reg(idx, value);
        end else if (prdata !== APB_DW'(tracker.read_reg(idx))) begin
            $error("prdata mismatch on %s: expected %0d, actual %0d",
                   idx.name(), tracker.read_reg(idx), prdata);
            tracker.failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // new thresholds only once the block has gone idle, each one read back
    task automatic set_thresholds(input logic [TIMER_W-1:0] sm, ll, ir);
        logic [TIMER_W-1:0] vals [3];
        vals = '{sm, ll, ir};
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        for (int k = 0; k < 3; k++) begin
            reg_access(1'b1, reg_idx_t'(k), vals[k]);
            reg_access(1'b0, reg_idx_t'(k), '0);
        end
    endtask

    // receiver: random ready runs and stall bursts, plus one long hold-off
    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int odds;
        logic [TIMER_W-1:0] sm, ll, ir;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FUNC_SCAN;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // thresholds must read back their reset values
        for (int k = 0; k < 3; k++)
            reg_access(1'b0, reg_idx_t'(k), '0);

        // directed: short limits so short, long and idle clearing all show up quickly
        set_thresholds(16'd1, 16'd6, 16'd4);
        issue(FUNC_RD_PRESS, 8'hFF, 3'd0);        // nothing pressed after reset
        issue(FUNC_SCAN, 8'h00, 3'd7);            // every button pressed at once
        issue(FUNC_RD_PRESS, 8'h00, 3'd7);
        repeat (2) issue(FUNC_SCAN, 8'h00, 3'd0);
        issue(FUNC_SCAN, 8'hF0, 3'd5);            // upper half released inside short window
        issue(FUNC_RD_SHORT, 8'hFF, 3'd4);
        issue(FUNC_RD_SHORT, 8'h00, 3'd4);        // flag already cleared by the read
        issue(FUNC_RD_LONG, 8'hAA, 3'd0);
        repeat (5) issue(FUNC_SCAN, 8'hF0, 3'd0); // lower half held past the long limit
        issue(FUNC_RD_LONG, 8'h55, 3'd3);
        issue(FUNC_RD_LONG, 8'h55, 3'd3);
        issue(FUNC_RD_SHORT, 8'h0F, 3'd5);        // unread short flag before idle clear
        issue(FUNC_SCAN, 8'hF0, 3'd2);
        issue(FUNC_RD_SHORT, 8'hF0, 3'd6);        // dropped by the idle timeout
        issue(FUNC_RD_PRESS, 8'hFF, 3'd3);
        issue(FUNC_SCAN, 8'hFF, 3'd7);            // release after a long press, no short
        issue(FUNC_RD_PRESS, 8'h00, 3'd0);
        issue(FUNC_RD_SHORT, 8'h00, 3'd0);
        levels_now = '1;

        // random phases, each with its own thresholds
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin
                    sm = 16'd0; ll = 16'd0; ir = 16'd0;
                end
                1: begin
                    sm = 16'd1; ll = 16'd12; ir = 16'd20;
                end
                3: begin
                    sm = SHORT_MIN_RST; ll = LONG_LIMIT_RST; ir = IDLE_RESET_RST;
                end
                5: begin
                    sm = 16'hFFFF; ll = 16'd16; ir = 16'hFFFF;
                end
                default: begin
                    sm = TIMER_W'($urandom_range(0, 4));
                    ll = TIMER_W'($urandom_range(1, 24));
                    ir = TIMER_W'($urandom_range(0, 30));
                end
            endcase
            // the final phase runs without any idling on either side
            if (p == 6) begin
                calm  = 1'b1;
                quiet = 1'b1;
            end
            set_thresholds(sm, ll, ir);
            odds = (int'(ll) > 76) ? 40 : int'(ll) / 2 + 2;

            // receiver holds off while queries keep coming, so the input backs up
            if (p == 1) begin
                hold_req = 1'b1;
                calm = 1'b1;
                repeat (30) random_item(100, odds);
                calm = 1'b0;
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // midway through phase 3 the sender pauses until every answer is back
                if (p == 3 && n == PHASE_ITEMS / 2)
                    drain();
                random_item(40, odds);
            end
        end

        drain();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (tracker.pending() != 0) begin
            $error("answer: %0d expected answers never arrived", tracker.pending());
            tracker.failures++;
        end
        if (tracker.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== button_press_classifier_unit.f =====
src/bpc_pkg.sv
src/bpc_cfg.sv
src/bpc_cell.sv
src/button_press_classifier_unit.sv
tb/press_tracker_pkg.sv
tb/tb_top.sv
